[hw/rtl/clrm_pkg.sv]
// ----------------------------------------------------------------------------
// clrm_pkg
// Shared types, codes and power-on line contents for the character display
// refresh and marquee unit.
// ----------------------------------------------------------------------------
package clrm_pkg;

    localparam int LINE_STORE_DEPTH_DEF = 64;
    localparam int VISIBLE_COLUMNS_DEF  = 16;
    localparam int UPPER_LEN_RESET      = 16;

    // Input command codes
    localparam logic [1:0] CMD_STORE   = 2'd0;
    localparam logic [1:0] CMD_COMMIT  = 2'd1;
    localparam logic [1:0] CMD_REFRESH = 2'd2;

    // Line select codes
    localparam logic [1:0] LINE_UPPER = 2'd0;
    localparam logic [1:0] LINE_LOWER = 2'd1;

    // Display command bytes
    localparam logic [7:0] LCD_CLEAR = 8'h01;
    localparam logic [7:0] LCD_HOME  = 8'h02;
    localparam logic [7:0] LCD_LINE2 = 8'hC0;
    localparam logic [7:0] PAD_CHAR  = 8'h20;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_HOME_C,
        S_ERR,
        S_HOME_R,
        S_UPPER,
        S_LINE2,
        S_LOWER
    } t_state;

    typedef enum logic [2:0] {
        OUT_CLEAR,
        OUT_HOME,
        OUT_LINE2,
        OUT_ERROR,
        OUT_CHAR
    } t_out_sel;

    typedef struct packed {
        logic     load_out;
        t_out_sel out_sel;
        logic     out_last;
        logic     col_clr;
        logic     col_inc;
        logic     rd_en;
        logic     rd_lower;
        logic     wr_store;
        logic     set_len;
        logic     rewind;
        logic     adv_offset;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;
        logic col_last;
    } t_dp_stat;

    // Power-on store contents; past the banner, entries 16 and 62 up are zero.
    function automatic logic [7:0] init_byte(input logic lower, input logic [7:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx < 8'd16) begin
            b = PAD_CHAR;
            if (!lower) begin
                case (idx)
                    8'd4:    b = 8'h41;
                    8'd5:    b = 8'h50;
                    8'd6:    b = 8'h41;
                    8'd7:    b = 8'h47;
                    8'd8:    b = 8'h41;
                    8'd9:    b = 8'h44;
                    8'd10:   b = 8'h4F;
                    default: b = PAD_CHAR;
                endcase
            end
        end else if (idx inside {[8'd17:8'd25]}) begin
            b = 8'h72 + (idx - 8'd17);
        end else if (idx inside {[8'd26:8'd51]}) begin
            b = 8'h41 + (idx - 8'd26);
        end else if (idx inside {[8'd52:8'd61]}) begin
            b = 8'h30 + (idx - 8'd52);
        end
        return b;
    endfunction

endpackage

[hw/rtl/char_lcd_refresh_marquee_unit.sv]
// ----------------------------------------------------------------------------
// char_lcd_refresh_marquee_unit
// Refresh engine for a two-line character display with a scrolling upper line.
// ----------------------------------------------------------------------------
// A store transaction writes one character to a valid line and gives no result.
// A commit sends clear and home (two results); the input stays held off from the
// accept cycle until both bytes are loaded. A commit to an invalid line sends
// one error result. A refresh tick sends 34 bytes, one per cycle when the sink
// keeps ready high: home, 16 upper characters from the scroll window, set-DDRAM
// 0xC0 and 16 lower characters, paced by the registered read port of the line
// stores, which is fetched one column ahead. The next transaction is taken the
// cycle after the last byte is loaded into the output register. The line stores
// hold their power-on text with no clearing pass; every entry has a written
// flag that reset clears.
// ----------------------------------------------------------------------------
module char_lcd_refresh_marquee_unit #(
    parameter int LINE_STORE_DEPTH = clrm_pkg::LINE_STORE_DEPTH_DEF,
    parameter int VISIBLE_COLUMNS  = clrm_pkg::VISIBLE_COLUMNS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_command,
    input  logic [1:0] i_line_select,
    input  logic [5:0] i_char_position,
    input  logic [7:0] i_char_value,
    input  logic [7:0] i_text_length,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_lcd_byte,
    output logic       o_is_data,
    output logic       o_error,
    output logic       o_last
);

    clrm_pkg::t_dp_cmd  dp_cmd;
    clrm_pkg::t_dp_stat dp_stat;

    clrm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_line_select (i_line_select),
        .i_stat        (dp_stat),
        .o_cmd         (dp_cmd)
    );

    clrm_datapath #(
        .LINE_STORE_DEPTH (LINE_STORE_DEPTH),
        .VISIBLE_COLUMNS  (VISIBLE_COLUMNS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_line_select   (i_line_select),
        .i_char_position (i_char_position),
        .i_char_value    (i_char_value),
        .i_text_length   (i_text_length),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_lcd_byte      (o_lcd_byte),
        .o_is_data       (o_is_data),
        .o_error         (o_error),
        .o_last          (o_last)
    );

endmodule

[hw/rtl/clrm_ctrl.sv]
// ----------------------------------------------------------------------------
// clrm_ctrl
// Sequencer: accepts one transaction at a time and steps the datapath through
// the display bytes of a commit or a refresh.
// ----------------------------------------------------------------------------
module clrm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_command,
    input  logic [1:0]        i_line_select,
    input  clrm_pkg::t_dp_stat i_stat,
    output clrm_pkg::t_dp_cmd  o_cmd
);

    clrm_pkg::t_state r_state;
    clrm_pkg::t_state n_state;
    logic             accept;
    logic             line_ok;

    assign o_in_ready = (r_state == clrm_pkg::S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign line_ok    = (i_line_select == clrm_pkg::LINE_UPPER)
                     || (i_line_select == clrm_pkg::LINE_LOWER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clrm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.out_sel = clrm_pkg::OUT_CHAR;
        case (r_state)
            clrm_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_command)
                        clrm_pkg::CMD_STORE: begin
                            o_cmd.wr_store = line_ok;
                        end
                        clrm_pkg::CMD_COMMIT: begin
                            if (line_ok) begin
                                o_cmd.set_len = (i_line_select == clrm_pkg::LINE_UPPER);
                                o_cmd.rewind  = 1'b1;
                                n_state       = clrm_pkg::S_CLEAR;
                            end else begin
                                n_state = clrm_pkg::S_ERR;
                            end
                        end
                        clrm_pkg::CMD_REFRESH: begin
                            n_state = clrm_pkg::S_HOME_R;
                        end
                        default: begin
                            n_state = clrm_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            clrm_pkg::S_CLEAR: begin
                if (i_stat.slot_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_sel  = clrm_pkg::OUT_CLEAR;
                    n_state        = clrm_pkg::S_HOME_C;
                end
            end
            clrm_pkg::S_HOME_C: begin
                if (i_stat.slot_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_sel  = clrm_pkg::OUT_HOME;
                    o_cmd.out_last = 1'b1;
                    n_state        = clrm_pkg::S_IDLE;
                end
            end
            clrm_pkg::S_ERR: begin
                if (i_stat.slot_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_sel  = clrm_pkg::OUT_ERROR;
                    o_cmd.out_last = 1'b1;
                    n_state        = clrm_pkg::S_IDLE;
                end
            end
            clrm_pkg::S_HOME_R: begin
                // prefetch the first upper character with the home byte
                if (i_stat.slot_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_sel  = clrm_pkg::OUT_HOME;
                    o_cmd.col_clr  = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    n_state        = clrm_pkg::S_UPPER;
                end
            end
            clrm_pkg::S_UPPER: begin
                if (i_stat.slot_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_sel  = clrm_pkg::OUT_CHAR;
                    o_cmd.col_inc  = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    if (i_stat.col_last) begin
                        o_cmd.adv_offset = 1'b1;
                        n_state          = clrm_pkg::S_LINE2;
                    end
                end
            end
            clrm_pkg::S_LINE2: begin
                if (i_stat.slot_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_sel  = clrm_pkg::OUT_LINE2;
                    o_cmd.col_clr  = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_lower = 1'b1;
                    n_state        = clrm_pkg::S_LOWER;
                end
            end
            clrm_pkg::S_LOWER: begin
                if (i_stat.slot_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_sel  = clrm_pkg::OUT_CHAR;
                    o_cmd.out_last = i_stat.col_last;
                    o_cmd.col_inc  = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_lower = 1'b1;
                    if (i_stat.col_last) begin
                        n_state = clrm_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = clrm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/clrm_datapath.sv]
// ----------------------------------------------------------------------------
// clrm_datapath
// Line stores, text length, scroll offset, column counter and the output
// register for display bytes.
// ----------------------------------------------------------------------------
module clrm_datapath #(
    parameter int LINE_STORE_DEPTH = clrm_pkg::LINE_STORE_DEPTH_DEF,
    parameter int VISIBLE_COLUMNS  = clrm_pkg::VISIBLE_COLUMNS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  clrm_pkg::t_dp_cmd  i_cmd,
    output clrm_pkg::t_dp_stat o_stat,
    input  logic [1:0]         i_line_select,
    input  logic [5:0]         i_char_position,
    input  logic [7:0]         i_char_value,
    input  logic [7:0]         i_text_length,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_lcd_byte,
    output logic               o_is_data,
    output logic               o_error,
    output logic               o_last
);

    localparam int AW = $clog2(LINE_STORE_DEPTH);
    localparam int LW = $clog2(LINE_STORE_DEPTH + 1);
    localparam int CW = $clog2(VISIBLE_COLUMNS);
    localparam int IW = $clog2(LINE_STORE_DEPTH + VISIBLE_COLUMNS + 1);

    logic [7:0]                  upper_mem [LINE_STORE_DEPTH];
    logic [7:0]                  lower_mem [LINE_STORE_DEPTH];
    logic [LINE_STORE_DEPTH-1:0] r_upper_vld;
    logic [LINE_STORE_DEPTH-1:0] r_lower_vld;

    logic [LW-1:0] r_len;
    logic [AW-1:0] r_off;
    logic [CW-1:0] r_col;
    logic          r_ended;

    logic [7:0]    r_rd_data;
    logic [7:0]    r_rd_init;
    logic          r_rd_vld;
    logic          r_rd_beyond;

    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_is_data;
    logic          r_out_error;
    logic          r_out_last;

    logic          slot_free;
    logic          pos_ok;
    logic [AW-1:0] wr_addr;
    logic [CW:0]   rd_col;
    logic [IW-1:0] rd_idx;
    logic [AW-1:0] rd_addr;
    logic          rd_beyond;
    logic [7:0]    ch;
    logic          ended_now;
    logic [LW:0]   off_inc;
    logic [7:0]    n_out_byte;
    logic          n_out_is_data;
    logic          n_out_error;

    assign slot_free        = !r_out_valid || i_out_ready;
    assign o_stat.slot_free = slot_free;
    assign o_stat.col_last  = (r_col == CW'(VISIBLE_COLUMNS - 1));

    assign pos_ok  = (32'(i_char_position) < LINE_STORE_DEPTH);
    assign wr_addr = AW'(i_char_position);

    // read address runs one column ahead of the byte being sent
    assign rd_col    = i_cmd.col_clr ? '0 : ((CW+1)'(r_col) + 1'b1);
    assign rd_idx    = (i_cmd.rd_lower ? IW'(0) : IW'(r_off)) + IW'(rd_col);
    assign rd_addr   = rd_idx[AW-1:0];
    assign rd_beyond = (32'(rd_idx) >= LINE_STORE_DEPTH);

    assign ch        = r_rd_beyond ? 8'h00 : (r_rd_vld ? r_rd_data : r_rd_init);
    assign ended_now = r_ended || (ch == 8'h00);
    assign off_inc   = (LW+1)'(r_off) + 1'b1;

    // line stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_store && pos_ok) begin
            if (i_line_select == clrm_pkg::LINE_UPPER) begin
                upper_mem[wr_addr] <= i_char_value;
            end else begin
                lower_mem[wr_addr] <= i_char_value;
            end
        end
        if (i_cmd.rd_en) begin
            r_rd_data   <= i_cmd.rd_lower ? lower_mem[rd_addr] : upper_mem[rd_addr];
            r_rd_vld    <= i_cmd.rd_lower ? r_lower_vld[rd_addr] : r_upper_vld[rd_addr];
            r_rd_init   <= clrm_pkg::init_byte(i_cmd.rd_lower, 8'(rd_addr));
            r_rd_beyond <= rd_beyond;
        end
    end

    // an entry never written reads its power-on contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_vld <= '0;
            r_lower_vld <= '0;
        end else if (i_cmd.wr_store && pos_ok) begin
            if (i_line_select == clrm_pkg::LINE_UPPER) begin
                r_upper_vld[wr_addr] <= 1'b1;
            end else begin
                r_lower_vld[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LW'(clrm_pkg::UPPER_LEN_RESET);
            r_off   <= '0;
            r_col   <= '0;
            r_ended <= 1'b0;
        end else begin
            if (i_cmd.set_len) begin
                r_len <= (32'(i_text_length) > LINE_STORE_DEPTH)
                       ? LW'(LINE_STORE_DEPTH) : LW'(i_text_length);
            end
            if (i_cmd.rewind) begin
                r_off <= '0;
            end else if (i_cmd.adv_offset && (32'(r_len) > VISIBLE_COLUMNS)) begin
                // wrap once the window would run past the text
                if (32'(off_inc) + VISIBLE_COLUMNS > 32'(r_len)) begin
                    r_off <= '0;
                end else begin
                    r_off <= AW'(off_inc);
                end
            end
            if (i_cmd.col_clr) begin
                r_col   <= '0;
                r_ended <= 1'b0;
            end else if (i_cmd.col_inc) begin
                r_col   <= r_col + 1'b1;
                r_ended <= ended_now;
            end
        end
    end

    always_comb begin
        n_out_byte    = 8'h00;
        n_out_is_data = 1'b0;
        n_out_error   = 1'b0;
        case (i_cmd.out_sel)
            clrm_pkg::OUT_CLEAR: n_out_byte = clrm_pkg::LCD_CLEAR;
            clrm_pkg::OUT_HOME:  n_out_byte = clrm_pkg::LCD_HOME;
            clrm_pkg::OUT_LINE2: n_out_byte = clrm_pkg::LCD_LINE2;
            clrm_pkg::OUT_ERROR: n_out_error = 1'b1;
            clrm_pkg::OUT_CHAR: begin
                n_out_byte    = ended_now ? clrm_pkg::PAD_CHAR : ch;
                n_out_is_data = 1'b1;
            end
            default: n_out_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_byte    <= n_out_byte;
            r_out_is_data <= n_out_is_data;
            r_out_error   <= n_out_error;
            r_out_last    <= i_cmd.out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_lcd_byte  = r_out_byte;
    assign o_is_data   = r_out_is_data;
    assign o_error     = r_out_error;
    assign o_last      = r_out_last;

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> slot_free)
        else $error("output register loaded while occupied");

    a_off_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_len) <= VISIBLE_COLUMNS) |-> (r_off == '0))
        else $error("scroll offset moved on a short upper line");

    a_off_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_len) > VISIBLE_COLUMNS) |-> (32'(r_off) + VISIBLE_COLUMNS <= 32'(r_len)))
        else $error("scroll window runs past the upper text");
`endif

endmodule
